@@ src/gsa_pkg.sv @@
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and codes for the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_CHECK = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch request word, launch memory reads
        logic exec;     // update state, load result register
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage

@@ src/gsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// gsa_ctrl
// Two-state sequencer: accept a request word, then execute it once the
// result register can take the answer.
// ----------------------------------------------------------------------------
module gsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_m_tready,
    input  gsa_pkg::t_dp_stat i_stat,
    output gsa_pkg::t_ctl    o_ctl,
    output logic             o_s_tready
);
    import gsa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   out_free;

    assign out_free = !i_stat.out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = 1'b0;
        o_ctl.accept = 1'b0;
        o_ctl.exec   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_ctl.accept = i_s_tvalid;
            end
            S_EXEC: begin
                o_ctl.exec = out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/gsa_dpath.sv @@
// ----------------------------------------------------------------------------
// gsa_dpath
// Free-list head, link and generation memories, active count and the
// result register. Entries at or above the fresh mark were never written:
// their link reads as index+1 and their generation word as zero.
// ----------------------------------------------------------------------------
module gsa_dpath #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gsa_pkg::t_ctl                        i_ctl,
    input  logic [gsa_pkg::IN_TDATA_W-1:0]       i_tdata,
    input  logic                                 i_m_tready,
    output gsa_pkg::t_dp_stat                    o_stat,
    output logic [gsa_pkg::OUT_TDATA_W-1:0]      o_tdata
);
    import gsa_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int HW = IW + 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [HW-1:0] HEAD_NONE = HW'(SLOT_COUNT);

    // memories: link and {occupied, generation}
    logic [HW-1:0] link_mem [SLOT_COUNT];
    logic [32:0]   slot_mem [SLOT_COUNT];

    logic [HW-1:0] r_head;
    logic [HW-1:0] r_fresh;
    logic [CW-1:0] r_count;

    logic [1:0]    r_func;
    logic [6:0]    r_idx;
    logic [31:0]   r_gen;
    logic [IW-1:0] r_addr;
    logic [HW-1:0] r_link_rd;
    logic [32:0]   r_slot_rd;

    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [5:0]    r_gidx;
    logic [31:0]   r_ggen;
    logic [6:0]    r_active;

    // request fields
    logic [1:0]    in_func;
    logic [6:0]    in_idx;
    logic [31:0]   in_gen;
    logic [31:0]   in_idx_ext;
    logic [IW-1:0] rd_addr;

    assign in_func    = i_tdata[1:0];
    assign in_idx     = i_tdata[8:2];
    assign in_gen     = i_tdata[40:9];
    assign in_idx_ext = 32'(in_idx);
    assign rd_addr    = (in_func == FN_ALLOC) ? r_head[IW-1:0] : in_idx_ext[IW-1:0];

    // execute-stage decode
    logic          fresh_hit;
    logic [32:0]   slot_word;
    logic [HW-1:0] link_word;
    logic          in_range;
    logic          handle_ok;
    logic [31:0]   addr_ext;
    logic [31:0]   count_ext;
    logic          do_alloc;
    logic          do_free;
    logic [1:0]    n_status;
    logic [5:0]    n_gidx;
    logic [31:0]   n_ggen;
    logic [CW-1:0] n_count;

    assign fresh_hit = ({1'b0, r_addr} >= r_fresh);
    assign slot_word = fresh_hit ? 33'd0 : r_slot_rd;
    assign link_word = fresh_hit ? ({1'b0, r_addr} + HW'(1)) : r_link_rd;
    assign in_range  = (32'(r_idx) < 32'(SLOT_COUNT));
    assign handle_ok = in_range && slot_word[32] && (slot_word[31:0] == r_gen);
    assign addr_ext  = 32'(r_addr);

    always_comb begin
        do_alloc = 1'b0;
        do_free  = 1'b0;
        n_status = ST_BAD;
        n_gidx   = '0;
        n_ggen   = '0;
        n_count  = r_count;
        unique case (t_func'(r_func))
            FN_ALLOC: begin
                if (r_head != HEAD_NONE) begin
                    do_alloc = 1'b1;
                    n_status = ST_OK;
                    n_gidx   = addr_ext[5:0];
                    n_ggen   = slot_word[31:0];
                    n_count  = r_count + CW'(1);
                end else begin
                    n_status = ST_FULL;
                end
            end
            FN_FREE: begin
                if (handle_ok) begin
                    do_free  = 1'b1;
                    n_status = ST_OK;
                    n_count  = r_count - CW'(1);
                end
            end
            FN_CHECK: begin
                if (handle_ok) begin
                    n_status = ST_OK;
                end
            end
            default: n_status = ST_BAD;
        endcase
    end

    assign count_ext = 32'(n_count);

    // request latch, registered memory reads and memory writes
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_func    <= in_func;
            r_idx     <= in_idx;
            r_gen     <= in_gen;
            r_addr    <= rd_addr;
            r_link_rd <= link_mem[rd_addr];
            r_slot_rd <= slot_mem[rd_addr];
        end
        if (i_ctl.exec && do_alloc) begin
            slot_mem[r_addr] <= {1'b1, slot_word[31:0]};
        end
        if (i_ctl.exec && do_free) begin
            slot_mem[r_addr] <= {1'b0, slot_word[31:0] + 32'd1};
            link_mem[r_addr] <= r_head;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.exec) begin
                r_count <= n_count;
                if (do_alloc) begin
                    r_head <= link_word;
                    if (fresh_hit) begin
                        r_fresh <= r_fresh + HW'(1);
                    end
                end
                if (do_free) begin
                    r_head <= {1'b0, r_addr};
                end
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_status <= n_status;
            r_gidx   <= n_gidx;
            r_ggen   <= n_ggen;
            r_active <= count_ext[6:0];
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_tdata = {1'b0, r_active, r_ggen, r_gidx, r_status};

endmodule

@@ src/generational_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Slot pool on a LIFO free list with a 32-bit generation per slot.
// The request word is latched on acceptance; the result is registered when
// the execute step finds the result register free. One request is in flight
// at a time, for the head/link read-modify-write via registered link reads.
// Reset: synchronous, active low; frees every slot with no clearing pass.
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
    parameter int SLOT_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] func, [8:2] slot_index, [40:9] handle_generation, rest zero
    input  logic [gsa_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [7:2] granted_index, [39:8] granted_generation,
    // [46:40] active_slots, rest zero
    output logic [gsa_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import gsa_pkg::*;

    t_ctl     ctl;
    t_dp_stat stat;

    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_s_tready (o_s_axis_tready)
    );

    gsa_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_tdata    (i_s_axis_tdata),
        .i_m_tready (i_m_axis_tready),
        .o_stat     (stat),
        .o_tdata    (o_m_axis_tdata)
    );

    assign o_m_axis_tvalid = stat.out_valid;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second word accepted before result produced");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.exec |=> o_m_axis_tvalid)
        else $error("execute did not load result register");

    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.accept |-> !ctl.exec)
        else $error("accept and execute in the same cycle");

endmodule
